// File: hdl/ncube_pkg.sv
`default_nettype none

package ncube_pkg;

  // Field widths of the item channels and the configuration register.
  localparam int FACE_W = 3;
  localparam int IDX_W  = 10;
  localparam int SIZE_W = 11;
  localparam int BYTE_W = 8;

  // Face size after reset.
  localparam int SIZE_RESET = 64;

  // Fixed point of the reciprocal length and of the normalized components.
  localparam int FRAC_BITS = 24;
  // Quotient bits of 2^(2*FRAC_BITS) / len2; a length of one needs them all.
  localparam int QW = 2 * FRAC_BITS + 1;
  // Bits of the reciprocal square root.
  localparam int RW = FRAC_BITS + 1;

  // Byte of a zero component.
  localparam logic [BYTE_W-1:0] BYTE_MID = 8'd127;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              index_error;
  } texel_t;

endpackage

`default_nettype wire

// File: hdl/ncube_if.sv
`default_nettype none

interface ncube_in_if;
  logic                         valid;
  logic                         ready;
  logic [ncube_pkg::FACE_W-1:0] face;
  logic [ncube_pkg::IDX_W-1:0]  row;
  logic [ncube_pkg::IDX_W-1:0]  column;

  modport source (output valid, output face, output row, output column, input ready);
  modport sink   (input valid, input face, input row, input column, output ready);
endinterface

interface ncube_out_if;
  logic                         valid;
  logic                         ready;
  logic [ncube_pkg::BYTE_W-1:0] red;
  logic [ncube_pkg::BYTE_W-1:0] green;
  logic [ncube_pkg::BYTE_W-1:0] blue;
  logic                         index_error;

  modport source (output valid, output red, output green, output blue,
                  output index_error, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input index_error, output ready);
endinterface

`default_nettype wire

// File: hdl/ncube_vec.sv
`default_nettype none

// Front end: range check and direction vector, squares, squared length.
module ncube_vec #(
  parameter int MAX_FACE_SIZE = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic [ncube_pkg::FACE_W-1:0]          face,
  input  wire logic [ncube_pkg::IDX_W-1:0]           row,
  input  wire logic [ncube_pkg::IDX_W-1:0]           column,
  input  wire logic [$clog2(MAX_FACE_SIZE+1)-1:0]    size,
  output logic                                       out_valid,
  output logic signed [$clog2(MAX_FACE_SIZE+1)-1:0]  comp [3],
  output logic                                       err,
  output logic                                       zero,
  output logic [2*$clog2(MAX_FACE_SIZE+1)-1:0]       len2
);

  localparam int SZW = $clog2(MAX_FACE_SIZE + 1);
  localparam int HW  = SZW - 1;
  localparam int CW  = HW + 1;
  localparam int EW  = ((ncube_pkg::IDX_W > SZW) ? ncube_pkg::IDX_W : SZW) + 1;
  localparam int SQW = 2 * HW;
  localparam int LW  = SQW + 2;

  logic [EW-1:0]        size_e, row_e, col_e;
  logic signed [EW-1:0] h_s, r_s, c_s;
  logic signed [EW-1:0] x_e, y_e, z_e;
  logic                 err_a_nxt;

  logic                 va_r, vb_r, vc_r;
  logic signed [CW-1:0] ca_r [3];
  logic signed [CW-1:0] cb_r [3];
  logic signed [CW-1:0] cc_r [3];
  logic [SQW-1:0]       sq_r [3];
  logic                 erra_r, errb_r, errc_r;
  logic [LW-1:0]        len2_nxt, len2_r;
  logic                 zero_r;

  assign size_e = {{(EW-SZW){1'b0}}, size};
  assign row_e  = {{(EW-ncube_pkg::IDX_W){1'b0}}, row};
  assign col_e  = {{(EW-ncube_pkg::IDX_W){1'b0}}, column};
  assign h_s    = $signed(size_e >> 1);
  assign r_s    = $signed(row_e);
  assign c_s    = $signed(col_e);

  assign err_a_nxt = (face > ncube_pkg::FACE_NZ) || (row_e >= size_e) || (col_e >= size_e);

  always_comb begin
    x_e = h_s;
    y_e = h_s - r_s;
    z_e = h_s - c_s;
    case (face)
      ncube_pkg::FACE_PX: begin
        x_e = h_s;       y_e = h_s - r_s; z_e = h_s - c_s;
      end
      ncube_pkg::FACE_NX: begin
        x_e = -h_s;      y_e = h_s - r_s; z_e = c_s - h_s;
      end
      ncube_pkg::FACE_PY: begin
        x_e = c_s - h_s; y_e = h_s;       z_e = r_s - h_s;
      end
      ncube_pkg::FACE_NY: begin
        x_e = c_s - h_s; y_e = -h_s;      z_e = h_s - r_s;
      end
      ncube_pkg::FACE_PZ: begin
        x_e = c_s - h_s; y_e = h_s - r_s; z_e = h_s;
      end
      ncube_pkg::FACE_NZ: begin
        x_e = h_s - c_s; y_e = h_s - r_s; z_e = -h_s;
      end
      default: begin
        x_e = h_s;       y_e = h_s;       z_e = h_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // Within the face every component lies in [-half, half], so it fits CW bits.
  always_ff @(posedge clk) begin
    if (en) begin
      ca_r[0] <= x_e[CW-1:0];
      ca_r[1] <= y_e[CW-1:0];
      ca_r[2] <= z_e[CW-1:0];
      erra_r  <= err_a_nxt;
      errb_r  <= erra_r;
      errc_r  <= errb_r;
      len2_r  <= len2_nxt;
      zero_r  <= (len2_nxt == '0);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [2*CW-1:0] sq;
    assign sq = ca_r[l] * ca_r[l];
    always_ff @(posedge clk) begin
      if (en) begin
        cb_r[l] <= ca_r[l];
        cc_r[l] <= cb_r[l];
        sq_r[l] <= sq[SQW-1:0];
      end
    end
    assign comp[l] = cc_r[l];
  end

  assign len2_nxt = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};

  assign out_valid = vc_r;
  assign err       = errc_r;
  assign zero      = zero_r;
  assign len2      = len2_r;

endmodule

`default_nettype wire

// File: hdl/ncube_rsqrt.sv
`default_nettype none

// Truncated reciprocal square root with FRAC_BITS fraction bits:
// a restoring divider forms floor(2^(2*FRAC_BITS) / len2), one quotient bit
// per stage, and a digit-by-digit square root takes one root bit per stage.
module ncube_rsqrt #(
  parameter int LW = 22,
  parameter int SW = 35
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [LW-1:0]              len2,
  input  wire logic [SW-1:0]              in_side,
  output logic                            out_valid,
  output logic [ncube_pkg::RW-1:0]        recip,
  output logic [SW-1:0]                   out_side
);

  localparam int QW  = ncube_pkg::QW;
  localparam int RW  = ncube_pkg::RW;
  localparam int SRW = RW + 2;

  logic          dv_r    [QW];
  logic [QW-1:0] dq_r    [QW];
  logic [SW-1:0] dside_r [QW];
  logic [LW-1:0] drem_r  [QW-1];
  logic [LW-1:0] dlen_r  [QW-1];

  logic           sv_r    [RW];
  logic [RW-1:0]  sroot_r [RW];
  logic [SRW-1:0] srem_r  [RW];
  logic [SW-1:0]  sside_r [RW];
  logic [QW-1:0]  sq_r    [RW-1];

  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam logic BIT_IN = (i == 0);
    logic          pv;
    logic [LW-1:0] prem, plen;
    logic [QW-1:0] pq;
    logic [SW-1:0] pside;
    logic [LW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign plen  = len2;
      assign pq    = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = dv_r[i-1];
      assign prem  = drem_r[i-1];
      assign plen  = dlen_r[i-1];
      assign pq    = dq_r[i-1];
      assign pside = dside_r[i-1];
    end

    // The dividend is a single one bit followed by zeros.
    assign trial = {prem, BIT_IN};
    assign ge    = (trial >= {1'b0, plen});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i] <= 1'b0;
      end else if (en) begin
        dv_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[i]    <= {pq[QW-2:0], ge};
        dside_r[i] <= pside;
      end
    end

    if (i < QW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          drem_r[i] <= ge ? LW'(trial - {1'b0, plen}) : trial[LW-1:0];
          dlen_r[i] <= plen;
        end
      end
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic           pv;
    logic [RW-1:0]  proot;
    logic [SRW-1:0] prem;
    logic [QW-1:0]  pq;
    logic [SW-1:0]  pside;
    logic [2*RW-1:0] vext;
    logic [SRW+1:0] t, trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign pv    = dv_r[QW-1];
      assign proot = '0;
      assign prem  = '0;
      assign pq    = dq_r[QW-1];
      assign pside = dside_r[QW-1];
    end else begin : g_next
      assign pv    = sv_r[k-1];
      assign proot = sroot_r[k-1];
      assign prem  = srem_r[k-1];
      assign pq    = sq_r[k-1];
      assign pside = sside_r[k-1];
    end

    assign vext  = {{(2*RW-QW){1'b0}}, pq};
    assign t     = {prem, vext[2*(RW-1-k) +: 2]};
    assign trial = {{(SRW-RW){1'b0}}, proot, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (en) begin
        sv_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sroot_r[k] <= {proot[RW-2:0], ge};
        srem_r[k]  <= ge ? SRW'(t - trial) : t[SRW-1:0];
        sside_r[k] <= pside;
      end
    end

    if (k < RW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          sq_r[k] <= pq;
        end
      end
    end
  end

  assign out_valid = sv_r[RW-1];
  assign recip     = sroot_r[RW-1];
  assign out_side  = sside_r[RW-1];

endmodule

`default_nettype wire

// File: hdl/ncube_byte.sv
`default_nettype none

// Back end: scales each component by the reciprocal length and maps it to a byte.
module ncube_byte #(
  parameter int CW = 11
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic signed [CW-1:0]           comp [3],
  input  wire logic [ncube_pkg::RW-1:0]       recip,
  input  wire logic                           err,
  input  wire logic                           zero,
  output logic                                out_valid,
  output ncube_pkg::texel_t                   texel
);

  localparam int FB = ncube_pkg::FRAC_BITS;
  localparam int BW = ncube_pkg::BYTE_W;
  // A normalized component never exceeds 2^FB in magnitude.
  localparam int NW = FB + 2;
  localparam int PW = CW + ncube_pkg::RW + 1;

  logic                 v1_r, v2_r;
  logic signed [NW-1:0] n1_r [3];
  logic                 err1_r, zero1_r;
  logic [BW-1:0]        byte_v [3];
  ncube_pkg::texel_t    texel_nxt, texel_r;

  // floor((n + 2^FB) * 255 / 2^(FB+1)), clamped to a byte.
  function automatic logic [BW-1:0] to_byte(input logic signed [NW-1:0] n);
    logic signed [NW:0] biased;
    logic [NW-1:0]      mag;
    logic [NW+BW-1:0]   scaled;
    biased = $signed({n[NW-1], n}) + $signed({2'b00, 1'b1, {FB{1'b0}}});
    mag    = biased[NW] ? '0 : biased[NW-1:0];
    scaled = {mag, {BW{1'b0}}} - {{BW{1'b0}}, mag};
    to_byte = scaled[NW+BW-1] ? {BW{1'b1}} : scaled[NW+BW-2:FB+1];
  endfunction

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [PW-1:0] prod;
    assign prod = comp[l] * $signed({1'b0, recip});
    always_ff @(posedge clk) begin
      if (en) begin
        n1_r[l] <= prod[NW-1:0];
      end
    end
    assign byte_v[l] = to_byte(n1_r[l]);
  end

  always_comb begin
    if (err1_r) begin
      texel_nxt = '{red: '0, green: '0, blue: '0, index_error: 1'b1};
    end else if (zero1_r) begin
      texel_nxt = '{red: ncube_pkg::BYTE_MID, green: ncube_pkg::BYTE_MID,
                    blue: ncube_pkg::BYTE_MID, index_error: 1'b0};
    end else begin
      texel_nxt = '{red: byte_v[0], green: byte_v[1], blue: byte_v[2], index_error: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err1_r  <= err;
      zero1_r <= zero;
      texel_r <= texel_nxt;
    end
  end

  assign out_valid = v2_r;
  assign texel     = texel_r;

endmodule

`default_nettype wire

// File: hdl/normalizing_cube_texel_gen.sv
// Throughput: one item per cycle while the skid register is empty; the 49-stage quotient
// divider and the 25-stage root extractor each retire one bit per stage, so every stage
// is free for a new item.
// Reset (synchronous, rst_n low) empties the pipeline and output buffer and sets
// face_size to 64.
`default_nettype none

module normalizing_cube_texel_gen #(
  parameter int MAX_FACE_SIZE = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ncube_in_if.sink                           in_tex,
  ncube_out_if.source                        out_tex,
  input  wire logic                          cfg_we,
  input  wire logic [ncube_pkg::SIZE_W-1:0]  cfg_data
);

  localparam int SZW = $clog2(MAX_FACE_SIZE + 1);
  localparam int CW  = SZW;
  localparam int LW  = 2 * SZW;
  localparam int SW  = 3 * CW + 2;
  localparam int CMW = (ncube_pkg::SIZE_W > SZW) ? ncube_pkg::SIZE_W : SZW;
  localparam int SIZE_RST = (ncube_pkg::SIZE_RESET > MAX_FACE_SIZE) ?
                            MAX_FACE_SIZE : ncube_pkg::SIZE_RESET;

  logic [SZW-1:0]       size_r, size_nxt;
  logic                 en;

  logic                 vec_valid, vec_err, vec_zero;
  logic signed [CW-1:0] vec_comp [3];
  logic [LW-1:0]        vec_len2;

  logic [SW-1:0]        side_in, side_out;
  logic                 rs_valid;
  logic [ncube_pkg::RW-1:0] rs_recip;
  logic signed [CW-1:0] rs_comp [3];

  logic                 up_valid;
  ncube_pkg::texel_t    up_texel;

  logic                 out_valid_r, sk_valid_r;
  ncube_pkg::texel_t    out_texel_r, sk_texel_r;

  // A face size beyond the largest supported one is saturated when written.
  assign size_nxt = (CMW'(cfg_data) > CMW'(MAX_FACE_SIZE)) ?
                    SZW'(MAX_FACE_SIZE) : SZW'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SZW'(SIZE_RST);
    end else if (cfg_we) begin
      size_r <= size_nxt;
    end
  end

  // The whole pipeline moves unless the skid register holds an item.
  assign en           = !sk_valid_r;
  assign in_tex.ready = en;

  ncube_vec #(
    .MAX_FACE_SIZE(MAX_FACE_SIZE)
  ) u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tex.valid),
    .face      (in_tex.face),
    .row       (in_tex.row),
    .column    (in_tex.column),
    .size      (size_r),
    .out_valid (vec_valid),
    .comp      (vec_comp),
    .err       (vec_err),
    .zero      (vec_zero),
    .len2      (vec_len2)
  );

  assign side_in = {vec_comp[0], vec_comp[1], vec_comp[2], vec_err, vec_zero};

  ncube_rsqrt #(
    .LW(LW),
    .SW(SW)
  ) u_rsqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vec_valid),
    .len2      (vec_len2),
    .in_side   (side_in),
    .out_valid (rs_valid),
    .recip     (rs_recip),
    .out_side  (side_out)
  );

  assign rs_comp[0] = side_out[SW-1 -: CW];
  assign rs_comp[1] = side_out[SW-1-CW -: CW];
  assign rs_comp[2] = side_out[SW-1-2*CW -: CW];

  ncube_byte #(
    .CW(CW)
  ) u_byte (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rs_valid),
    .comp      (rs_comp),
    .recip     (rs_recip),
    .err       (side_out[1]),
    .zero      (side_out[0]),
    .out_valid (up_valid),
    .texel     (up_texel)
  );

  // Output register with a skid register behind it, so that ready toward the
  // input comes from a flop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (!out_valid_r || out_tex.ready) begin
      out_valid_r <= sk_valid_r || up_valid;
      sk_valid_r  <= 1'b0;
    end else if (up_valid && en) begin
      sk_valid_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tex.ready) begin
      out_texel_r <= sk_valid_r ? sk_texel_r : up_texel;
    end else if (en) begin
      sk_texel_r  <= up_texel;
    end
  end

  assign out_tex.valid       = out_valid_r;
  assign out_tex.red         = out_texel_r.red;
  assign out_tex.green       = out_texel_r.green;
  assign out_tex.blue        = out_texel_r.blue;
  assign out_tex.index_error = out_texel_r.index_error;

endmodule

`default_nettype wire

// File: hdl/ncube_chk.sv
`default_nettype none

module ncube_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [ncube_pkg::BYTE_W-1:0] red,
  input wire logic [ncube_pkg::BYTE_W-1:0] green,
  input wire logic [ncube_pkg::BYTE_W-1:0] blue,
  input wire logic                         index_error
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) &&
                               $stable(blue) && $stable(index_error))
    else $error("result item changed while stalled");

  // A texel outside the face carries zero channels.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && index_error |-> red == '0 && green == '0 && blue == '0)
    else $error("index error with nonzero channels");

  // The block can only refuse items while a result waits at the output.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with an empty output");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind normalizing_cube_texel_gen ncube_chk u_ncube_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_tex.valid),
  .in_ready    (in_tex.ready),
  .out_valid   (out_tex.valid),
  .out_ready   (out_tex.ready),
  .red         (out_tex.red),
  .green       (out_tex.green),
  .blue        (out_tex.blue),
  .index_error (out_tex.index_error)
);

`default_nettype wire

// File: tb/tb_normalizing_cube_texel_gen.sv
`default_nettype none

module tb_normalizing_cube_texel_gen;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  localparam int MAX_SIZE = 1024;
  localparam longint ONE_FIX = 64'sd1 << ncube_pkg::FRAC_BITS;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [ncube_pkg::SIZE_W-1:0] cfg_data;

  ncube_in_if  in_tex();
  ncube_out_if out_tex();

  normalizing_cube_texel_gen #(.MAX_FACE_SIZE(MAX_SIZE)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tex  (in_tex),
    .out_tex (out_tex),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  logic [ncube_pkg::SIZE_W-1:0] face_size_model = ncube_pkg::SIZE_W'(ncube_pkg::SIZE_RESET);
  ncube_pkg::texel_t            pending_texels[$];
  ncube_pkg::texel_t            oldest_texel;
  int                           mismatches = 0;
  int                           send_idle_pct = 0;
  int                           recv_idle_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Largest root with root*root*len2 <= 2^48, i.e. 1/sqrt(len2) with 24 fraction bits.
  function automatic u64_t recip_length(input u64_t len2);
    u64_t bound;
    u64_t root;
    u64_t trial;
    bound = (u64_t'(1) << (2 * ncube_pkg::FRAC_BITS)) / len2;
    root = 0;
    for (int b = ncube_pkg::FRAC_BITS; b >= 0; b--) begin
      trial = root | (u64_t'(1) << b);
      if (trial * trial <= bound) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic logic [ncube_pkg::BYTE_W-1:0] component_byte(input longint comp,
                                                                  input u64_t rlen);
    longint biased;
    u64_t   scaled;
    biased = comp * longint'(rlen) + ONE_FIX;
    if (biased < 0) begin
      biased = 0;
    end
    scaled = (u64_t'(biased) * u64_t'(255)) >> (ncube_pkg::FRAC_BITS + 1);
    return (scaled > u64_t'(255)) ? 8'd255 : scaled[ncube_pkg::BYTE_W-1:0];
  endfunction

  function automatic ncube_pkg::texel_t predict_texel(
      input logic [ncube_pkg::FACE_W-1:0] face,
      input logic [ncube_pkg::IDX_W-1:0]  row,
      input logic [ncube_pkg::IDX_W-1:0]  column);
    ncube_pkg::texel_t t;
    longint size;
    longint half;
    longint row_i;
    longint col_i;
    longint x;
    longint y;
    longint z;
    u64_t   len2;
    u64_t   rlen;
    size = (longint'(face_size_model) > longint'(MAX_SIZE)) ?
           longint'(MAX_SIZE) : longint'(face_size_model);
    half = size / 2;
    row_i = longint'(row);
    col_i = longint'(column);
    t = '0;
    if (face > ncube_pkg::FACE_NZ || row_i >= size || col_i >= size) begin
      t.index_error = 1'b1;
      return t;
    end
    case (ncube_pkg::face_t'(face))
      ncube_pkg::FACE_PX: begin x = half;         y = half - row_i; z = half - col_i; end
      ncube_pkg::FACE_NX: begin x = -half;        y = half - row_i; z = col_i - half; end
      ncube_pkg::FACE_PY: begin x = col_i - half; y = half;         z = row_i - half; end
      ncube_pkg::FACE_NY: begin x = col_i - half; y = -half;        z = half - row_i; end
      ncube_pkg::FACE_PZ: begin x = col_i - half; y = half - row_i; z = half;         end
      default:            begin x = half - col_i; y = half - row_i; z = -half;        end
    endcase
    len2 = u64_t'(x * x + y * y + z * z);
    if (len2 == 0) begin
      t.red = ncube_pkg::BYTE_MID;
      t.green = ncube_pkg::BYTE_MID;
      t.blue = ncube_pkg::BYTE_MID;
      return t;
    end
    rlen = recip_length(len2);
    t.red = component_byte(x, rlen);
    t.green = component_byte(y, rlen);
    t.blue = component_byte(z, rlen);
    return t;
  endfunction

  task automatic check_field(input string name, input logic [ncube_pkg::BYTE_W-1:0] want,
                             input logic [ncube_pkg::BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each texel that leaves the block, then decide the receiver's next stall.
  always @(posedge clk) begin
    if (rst_n && out_tex.valid === 1'b1 && out_tex.ready === 1'b1) begin
      if (pending_texels.size() == 0) begin
        $error("texel arrived with no item outstanding");
        mismatches++;
      end else begin
        oldest_texel = pending_texels.pop_front();
        check_field("red", oldest_texel.red, out_tex.red);
        check_field("green", oldest_texel.green, out_tex.green);
        check_field("blue", oldest_texel.blue, out_tex.blue);
        check_field("index_error", ncube_pkg::BYTE_W'(oldest_texel.index_error),
                    ncube_pkg::BYTE_W'(out_tex.index_error));
      end
    end
    out_tex.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_texel(input logic [ncube_pkg::FACE_W-1:0] face,
                            input logic [ncube_pkg::IDX_W-1:0] row,
                            input logic [ncube_pkg::IDX_W-1:0] column);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tex.valid <= 1'b0;
      @(posedge clk);
    end
    in_tex.valid <= 1'b1;
    in_tex.face <= face;
    in_tex.row <= row;
    in_tex.column <= column;
    do @(posedge clk); while (in_tex.ready !== 1'b1);
    pending_texels.push_back(predict_texel(face, row, column));
  endtask

  task automatic drain_texels();
    in_tex.valid <= 1'b0;
    while (pending_texels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Every item yields a texel, so an empty queue means the pipeline is empty too.
  task automatic set_face_size(input int size);
    drain_texels();
    cfg_we <= 1'b1;
    cfg_data <= size[ncube_pkg::SIZE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    face_size_model = size[ncube_pkg::SIZE_W-1:0];
  endtask

  // Mostly texels on a valid face; the rest are wild indexes, boundary indexes and
  // faces six and seven.
  task automatic test_random_texels(input int count);
    int                           eff;
    int                           pick;
    logic [ncube_pkg::FACE_W-1:0] face;
    logic [ncube_pkg::IDX_W-1:0]  row;
    logic [ncube_pkg::IDX_W-1:0]  column;
    eff = (int'(face_size_model) > MAX_SIZE) ? MAX_SIZE : int'(face_size_model);
    for (int i = 0; i < count; i++) begin
      pick = int'($urandom_range(99));
      if (pick < 80 && eff > 0) begin
        face = ncube_pkg::FACE_W'($urandom_range(ncube_pkg::FACE_NZ));
        row = ncube_pkg::IDX_W'($urandom_range(eff - 1));
        column = ncube_pkg::IDX_W'($urandom_range(eff - 1));
      end else if (pick < 90) begin
        face = ncube_pkg::FACE_W'($urandom_range(ncube_pkg::FACE_NZ));
        row = ncube_pkg::IDX_W'(eff - int'($urandom_range(1)));
        column = ($urandom_range(1) == 0) ? ncube_pkg::IDX_W'(eff - 1) :
                                            ncube_pkg::IDX_W'(eff);
      end else begin
        face = ncube_pkg::FACE_W'($urandom_range(7));
        row = ncube_pkg::IDX_W'($urandom);
        column = ncube_pkg::IDX_W'($urandom);
      end
      send_texel(face, row, column);
    end
  endtask

  task automatic test_directed_corners();
    for (int f = ncube_pkg::FACE_PX; f <= ncube_pkg::FACE_NZ; f++) begin
      send_texel(ncube_pkg::FACE_W'(f), 10'd0, 10'd0);
      send_texel(ncube_pkg::FACE_W'(f), 10'd63, 10'd63);
    end
    // Face centers point straight along an axis.
    send_texel(ncube_pkg::FACE_PX, 10'd32, 10'd32);
    send_texel(ncube_pkg::FACE_NX, 10'd32, 10'd32);
    send_texel(ncube_pkg::FACE_PX, 10'd64, 10'd0);
    send_texel(ncube_pkg::FACE_PY, 10'd0, 10'd64);
    send_texel(ncube_pkg::FACE_NZ, 10'd1023, 10'd1023);
    send_texel(3'd6, 10'd0, 10'd0);
    send_texel(3'd7, 10'd10, 10'd10);
  endtask

  task automatic test_small_faces();
    set_face_size(0);
    send_texel(ncube_pkg::FACE_PX, 10'd0, 10'd0);
    send_texel(ncube_pkg::FACE_NY, 10'd1, 10'd0);
    // A face of one texel gives the zero vector at its only index.
    set_face_size(1);
    for (int f = ncube_pkg::FACE_PX; f <= ncube_pkg::FACE_NZ; f++) begin
      send_texel(ncube_pkg::FACE_W'(f), 10'd0, 10'd0);
    end
    send_texel(ncube_pkg::FACE_PX, 10'd0, 10'd1);
    set_face_size(2);
    test_random_texels(80);
  endtask

  task automatic test_largest_face();
    set_face_size(MAX_SIZE);
    test_random_texels(400);
  endtask

  task automatic test_saturated_size();
    set_face_size((1 << ncube_pkg::SIZE_W) - 1);
    test_random_texels(300);
  endtask

  task automatic test_size_sweep(input int sets, input int per_set);
    for (int s = 0; s < sets; s++) begin
      set_face_size(int'($urandom_range(MAX_SIZE, 2)));
      test_random_texels(per_set);
    end
  endtask

  task automatic test_odd_and_reset_sizes();
    set_face_size(ncube_pkg::SIZE_RESET);
    test_random_texels(150);
    set_face_size(MAX_SIZE - 1);
    test_random_texels(150);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_tex.valid <= 1'b0;
    in_tex.face <= '0;
    in_tex.row <= '0;
    in_tex.column <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 10;
    recv_idle_pct = 80;
    test_directed_corners();
    test_small_faces();
    test_largest_face();

    send_idle_pct = 80;
    recv_idle_pct = 10;
    test_saturated_size();
    test_size_sweep(2, 100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_odd_and_reset_sizes();
    test_size_sweep(2, 75);

    drain_texels();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
